// ----- design/lst_pkg.sv -----
package lst_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_VISIT,
    ST_RDW,
    ST_CHK,
    ST_PUSH_L,
    ST_PUSH_R,
    ST_DESCEND,
    ST_RET,
    ST_FIX_RD,
    ST_FIX_W,
    ST_FIX_WR,
    ST_DONE
  } lst_state_e;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_SUM = 1'b1;

  // largest usable element count; position fields are 13 bits wide
  localparam int MAX_ELEMENTS = 4096;

endpackage

// ----- design/lst_ram.sv -----
module lst_ram #(
  parameter int Width = 64,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/lazy_segment_tree_range_add_sum.sv -----
// Lazy segment tree: range add and range sum over positions 1..element_count.
// Channels: pulse start_i while busy_o is low with req_type_i, range_low_i,
// range_high_i and delta_i; the item transfers at that edge. One result per
// item appears on range_sum_o/range_error_o for exactly one cycle, marked by
// done_o; the receiver cannot stall, so nothing ever waits on the output.
// busy_o is high from the cycle after the transfer through the done_o cycle.
// Steps: a fully covered node is read, checked and returned; a partly
// covered node is read, checked, descended into and returned, pushes a
// pending tag into both children first when it holds one, and for an add
// rebuilds its sum from its children. A range meets at most two partial
// and two covered nodes per level; a whole-range query is answered at the
// root, and a rejected range raises done_o in the cycle after the transfer.
// Throughput: one item at a time; the next can transfer once busy_o falls.
// The sequencer drives one multiplier (tag or delta times span) and two RAMs
// (sums and pending tags), each with one read and one write port.
// Reset: element_count returns to 4096 and both RAMs are swept to zero,
// one node per cycle; busy_o is high during the sweep.
// cfg_we_i may be written at any time while busy_o is low.
module lazy_segment_tree_range_add_sum
  import lst_pkg::*;
#(
  parameter int NodeCount   = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [12:0] range_low_i,
  input  logic [12:0] range_high_i,
  input  logic signed [63:0] delta_i,
  output logic        done_o,
  output logic signed [63:0] range_sum_o,
  output logic        range_error_o
);

  localparam int AW = $clog2(NodeCount);
  localparam int SD = 2 ** $clog2(AW + 1); // at least one frame per tree level
  localparam int SW = $clog2(SD);
  localparam int DW = SW + 1; // stack pointer bits

  typedef struct packed {
    logic [AW:0] node;
    logic [12:0] lo;
    logic [12:0] hi;
    logic [1:0]  phase; // 0 entry, 1 after left, 2 after right
  } frame_t;

  lst_state_e state_q, state_d;
  logic [12:0] cnt_q;
  logic        kind_q;
  logic [12:0] a_q, b_q;
  logic [63:0] d_q, acc_q, acc_d;
  logic [63:0] sum_q, tag_q, tmp_q, tmp_d;
  logic [AW:0] clr_q, clr_d;
  logic        err_q, err_d;
  frame_t      stk_q [SD];
  logic [DW-1:0] sp_q, sp_d;
  frame_t      top, push_f;
  logic        do_push, do_pop, set_top;
  frame_t      set_f;
  logic [63:0] sum_q_d, tag_q_d;
  logic        ld_sum, ld_tag;

  // ram ports
  logic          s_we, t_we;
  logic [AW-1:0] s_wa, t_wa, s_ra, t_ra;
  logic [63:0]   s_wd, t_wd, s_rd, t_rd;

  lst_ram #(.Width(64), .Depth(NodeCount)) u_sum (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  lst_ram #(.Width(64), .Depth(NodeCount)) u_tag (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd));

  logic [12:0] n_eff, mid, span_l, span_r, span;
  logic        node_ok, lnode_ok, rnode_ok, leaf_cov;
  logic [AW:0] lnode, rnode;
  logic [63:0] mul_a;
  logic [12:0] mul_b;
  logic [63:0] mul_p;

  assign top   = stk_q[sp_q[SW-1:0] - 1'b1];
  assign n_eff = (cnt_q == '0) ? 13'd1 :
                 (cnt_q > 13'(MAX_ELEMENTS)) ? 13'(MAX_ELEMENTS) : cnt_q;
  assign mid   = 13'((14'(top.lo) + 14'(top.hi)) >> 1);
  assign span  = top.hi - top.lo + 13'd1;
  assign span_l = mid - top.lo + 13'd1;
  assign span_r = top.hi - mid;
  assign lnode = {top.node[AW-1:0], 1'b0};
  assign rnode = {top.node[AW-1:0], 1'b1};
  assign node_ok  = top.node < (AW+1)'(NodeCount);
  assign lnode_ok = !top.node[AW] && lnode < (AW+1)'(NodeCount);
  assign rnode_ok = !top.node[AW] && rnode < (AW+1)'(NodeCount);
  assign leaf_cov = (a_q <= top.lo && top.hi <= b_q) || top.lo == top.hi;
  // shared multiplier: tag or delta times span
  assign mul_p = mul_a * 64'(mul_b);

  always_comb begin
    state_d = state_q; clr_d = clr_q; err_d = err_q; acc_d = acc_q;
    sp_d = sp_q; do_push = 1'b0; do_pop = 1'b0; set_top = 1'b0;
    push_f = '0; set_f = top; tmp_d = tmp_q;
    sum_q_d = sum_q; tag_q_d = tag_q; ld_sum = 1'b0; ld_tag = 1'b0;
    s_we = 1'b0; t_we = 1'b0; s_wa = top.node[AW-1:0]; t_wa = top.node[AW-1:0];
    s_wd = '0; t_wd = '0; s_ra = top.node[AW-1:0]; t_ra = top.node[AW-1:0];
    mul_a = tag_q; mul_b = span;
    unique case (state_q)
      ST_CLEAR: begin
        s_we = 1'b1; t_we = 1'b1; s_wa = clr_q[AW-1:0]; t_wa = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(NodeCount - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          acc_d = '0;
          if (range_low_i == '0 || range_low_i > range_high_i || range_high_i > n_eff) begin
            err_d = 1'b1; state_d = ST_DONE;
          end else begin
            err_d = 1'b0; sp_d = DW'(1); state_d = ST_VISIT;
          end
        end
      end
      // read node sum and tag
      ST_VISIT: state_d = ST_RDW;
      ST_RDW: begin
        sum_q_d = node_ok ? s_rd : '0; tag_q_d = node_ok ? t_rd : '0;
        ld_sum = 1'b1; ld_tag = 1'b1; state_d = ST_CHK;
      end
      ST_CHK: begin
        if (leaf_cov) begin
          if (kind_q == REQ_SUM) begin
            acc_d = acc_q + sum_q;
          end else if (node_ok) begin
            mul_a = d_q; mul_b = span;
            t_we = 1'b1; t_wd = tag_q + d_q;
            s_we = 1'b1; s_wd = sum_q + mul_p;
          end
          state_d = ST_RET;
        end else if (tag_q != '0) begin
          tmp_d = '0; state_d = ST_PUSH_L; s_ra = lnode[AW-1:0]; t_ra = lnode[AW-1:0];
        end else begin
          state_d = ST_DESCEND;
        end
      end
      // push tag into left child (read issued previous cycle)
      ST_PUSH_L: begin
        if (tmp_q == '0) begin
          tmp_d = 64'd1; s_ra = lnode[AW-1:0]; t_ra = lnode[AW-1:0];
        end else begin
          mul_b = span_l;
          s_wa = lnode[AW-1:0]; t_wa = lnode[AW-1:0];
          s_we = lnode_ok; t_we = lnode_ok;
          s_wd = s_rd + mul_p; t_wd = t_rd + tag_q;
          s_ra = rnode[AW-1:0]; t_ra = rnode[AW-1:0];
          tmp_d = '0; state_d = ST_PUSH_R;
        end
      end
      ST_PUSH_R: begin
        if (tmp_q == '0) begin
          tmp_d = 64'd1; s_ra = rnode[AW-1:0]; t_ra = rnode[AW-1:0];
        end else begin
          mul_b = span_r;
          s_wa = rnode[AW-1:0]; t_wa = rnode[AW-1:0];
          s_we = rnode_ok; t_we = rnode_ok;
          s_wd = s_rd + mul_p; t_wd = t_rd + tag_q;
          t_we = rnode_ok;
          state_d = ST_DESCEND;
          tmp_d = '0;
        end
      end
      ST_DESCEND: begin
        // clear own tag after a push (written separately to keep ports single)
        if (tag_q != '0 && node_ok) begin
          t_we = 1'b1; t_wd = '0;
        end
        tag_q_d = '0; ld_tag = 1'b1;
        if (top.phase == 2'd0) begin
          set_top = 1'b1; set_f.phase = 2'd1;
          if (a_q <= mid) begin
            do_push = 1'b1; push_f = '{node: lnode, lo: top.lo, hi: mid, phase: 2'd0};
            state_d = ST_VISIT;
          end
        end else if (top.phase == 2'd1) begin
          set_top = 1'b1; set_f.phase = 2'd2;
          if (b_q > mid) begin
            do_push = 1'b1;
            push_f = '{node: rnode, lo: mid + 13'd1, hi: top.hi, phase: 2'd0};
            state_d = ST_VISIT;
          end
        end else begin
          state_d = (kind_q == REQ_ADD) ? ST_FIX_RD : ST_RET;
        end
      end
      // rebuild sum from children: left read lands in ST_FIX_W, right in ST_FIX_WR
      ST_FIX_RD: begin
        s_ra = lnode[AW-1:0]; tmp_d = '0; state_d = ST_FIX_W;
      end
      ST_FIX_W: begin
        s_ra = rnode[AW-1:0];
        tmp_d = lnode_ok ? s_rd : '0;
        state_d = ST_FIX_WR;
      end
      ST_FIX_WR: begin
        s_we = node_ok; s_wd = tmp_q + (rnode_ok ? s_rd : '0);
        state_d = ST_RET;
      end
      ST_RET: begin
        do_pop = 1'b1;
        if (sp_q == DW'(1)) state_d = ST_DONE;
        else state_d = ST_DESCEND;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (do_pop) sp_d = sp_q - 1'b1;
    if (do_push) sp_d = sp_q + 1'b1;
  end

  // the re-entry after pop must reload parent's tag as zero (already pushed)
  // and parent's phase continues in ST_DESCEND
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= 13'd4096;
      sp_q    <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      err_q   <= err_d;
      if (cfg_we_i) cnt_q <= cfg_wdata_i;
    end
  end

  // payload and frame stack
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    tmp_q <= tmp_d;
    if (ld_sum) sum_q <= sum_q_d;
    if (ld_tag || do_pop) tag_q <= ld_tag ? tag_q_d : '0;
    if (state_q == ST_IDLE && start_i) begin
      kind_q <= req_type_i; a_q <= range_low_i; b_q <= range_high_i; d_q <= delta_i;
      stk_q[0] <= '{node: (AW+1)'(1), lo: 13'd1, hi: n_eff, phase: 2'd0};
    end
    if (set_top) stk_q[sp_q[SW-1:0] - 1'b1] <= set_f;
    if (do_push) stk_q[sp_q[SW-1:0]] <= push_f;
  end

  assign busy_o        = state_q != ST_IDLE;
  assign done_o        = state_q == ST_DONE;
  assign range_error_o = err_q;
  assign range_sum_o   = (err_q || kind_q == REQ_ADD) ? '0 : acc_q;

endmodule

// ----- dv/testbench.sv -----
module testbench
  import lst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxElems  = 4096;
  localparam int TreeNodes = 8192;
  localparam int StallLimit = 200000;
  localparam int RandItems = 620;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [12:0]        cfg_wdata_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               req_type_i = REQ_ADD;
  logic [12:0]        range_low_i = '0;
  logic [12:0]        range_high_i = '0;
  logic signed [63:0] delta_i = '0;
  logic               done_o;
  logic signed [63:0] range_sum_o;
  logic               range_error_o;

  typedef struct packed {
    logic [63:0] sum;
    logic        err;
  } sum_result_t;

  // Shadow copy of the tree and the count register
  logic [63:0] shadow_sums [TreeNodes];
  logic [63:0] shadow_tags [TreeNodes];
  logic [12:0] shadow_count;

  sum_result_t pending_sums[$];
  int          error_count;
  int          idle_cycles;

  lazy_segment_tree_range_add_sum dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] node_rd(ref logic [63:0] mem [TreeNodes], input longint idx);
    return (idx < TreeNodes) ? mem[idx] : 64'd0;
  endfunction

  function automatic void node_wr(ref logic [63:0] mem [TreeNodes], input longint idx,
                                  input logic [63:0] v);
    if (idx < TreeNodes) mem[idx] = v;
  endfunction

  function automatic void tag_node(longint node, longint lo, longint hi, logic [63:0] d);
    node_wr(shadow_tags, node, node_rd(shadow_tags, node) + d);
    node_wr(shadow_sums, node, node_rd(shadow_sums, node) + d * 64'(hi - lo + 1));
  endfunction

  function automatic void spread_tag(longint node, longint lo, longint hi);
    logic [63:0] t;
    longint mid;
    t = node_rd(shadow_tags, node);
    mid = (lo + hi) >> 1;
    if (t != 0) begin
      tag_node(node * 2, lo, mid, t);
      tag_node(node * 2 + 1, mid + 1, hi, t);
      node_wr(shadow_tags, node, 64'd0);
    end
  endfunction

  function automatic void tree_add(longint a, longint b, longint node, longint lo, longint hi,
                                   logic [63:0] d);
    longint mid;
    if ((a <= lo && hi <= b) || lo == hi) begin
      tag_node(node, lo, hi, d);
      return;
    end
    spread_tag(node, lo, hi);
    mid = (lo + hi) >> 1;
    if (a <= mid) tree_add(a, b, node * 2, lo, mid, d);
    if (b > mid) tree_add(a, b, node * 2 + 1, mid + 1, hi, d);
    node_wr(shadow_sums, node,
            node_rd(shadow_sums, node * 2) + node_rd(shadow_sums, node * 2 + 1));
  endfunction

  function automatic logic [63:0] tree_sum(longint a, longint b, longint node, longint lo,
                                           longint hi);
    longint mid;
    logic [63:0] acc;
    acc = 0;
    if ((a <= lo && hi <= b) || lo == hi) return node_rd(shadow_sums, node);
    spread_tag(node, lo, hi);
    mid = (lo + hi) >> 1;
    if (a <= mid) acc += tree_sum(a, b, node * 2, lo, mid);
    if (b > mid) acc += tree_sum(a, b, node * 2 + 1, mid + 1, hi);
    return acc;
  endfunction

  function automatic sum_result_t predict_range(logic kind, logic [12:0] a, logic [12:0] b,
                                                logic [63:0] d);
    sum_result_t r;
    longint n;
    n = shadow_count;
    if (n == 0) n = 1;
    if (n > MaxElems) n = MaxElems;
    r = '0;
    if (a == 0 || a > b || b > n) begin
      r.err = 1'b1;
    end else if (kind == REQ_ADD) begin
      tree_add(a, b, 1, 1, n, d);
    end else begin
      r.sum = tree_sum(a, b, 1, 1, n);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Short gaps mostly, now and then a long one, sometimes none
  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return;
    if (r < 92) repeat ($urandom_range(1, 4)) @(negedge clk_i);
    else repeat ($urandom_range(20, 120)) @(negedge clk_i);
  endtask

  // Transfer one item and record its expected result
  task automatic send_range(logic kind, logic [12:0] a, logic [12:0] b, logic [63:0] d);
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    req_type_i   <= kind;
    range_low_i  <= a;
    range_high_i <= b;
    delta_i      <= d;
    start_i      <= 1'b1;
    pending_sums.push_back(predict_range(kind, a, b, d));
    @(negedge clk_i);
    start_i <= 1'b0;
    idle_gap();
  endtask

  task automatic drain();
    while (pending_sums.size() != 0) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic write_count(logic [12:0] v);
    drain();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_count = v;
  endtask

  function automatic logic [63:0] rand_delta();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return 64'($signed($urandom_range(0, 200)) - 100);
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      default: return 64'($urandom_range(0, 1000));
    endcase
  endfunction

  // Pick a range; mostly valid for the given count, sometimes rejected
  task automatic rand_item(int n);
    logic [12:0] a, b;
    int r;
    r = $urandom_range(0, 99);
    a = 13'($urandom_range(1, n));
    b = 13'($urandom_range(a, n));
    if (r < 15) begin
      a = 13'($urandom_range(0, 8191));
      b = 13'($urandom_range(0, 8191));
    end else if (r < 25 && n > 4) begin
      a = 13'($urandom_range(1, n));
      b = 13'($urandom_range(a, a + 3 > n ? n : a + 3));
    end
    send_range(1'($urandom_range(0, 1)), a, b, rand_delta());
  endtask

  task automatic test_directed_extremes();
    send_range(REQ_SUM, 13'd1, 13'd4096, 64'd0);
    send_range(REQ_ADD, 13'd1, 13'd4096, 64'h7fff_ffff_ffff_ffff);
    send_range(REQ_ADD, 13'd1, 13'd1, 64'h8000_0000_0000_0000);
    send_range(REQ_ADD, 13'd4096, 13'd4096, 64'hffff_ffff_ffff_ffff);
    send_range(REQ_ADD, 13'd100, 13'd2000, 64'h5555_aaaa_5555_aaaa);
    send_range(REQ_SUM, 13'd1, 13'd1, 64'hffff_ffff_ffff_ffff);
    send_range(REQ_SUM, 13'd4096, 13'd4096, 64'd0);
    send_range(REQ_SUM, 13'd50, 13'd2500, 64'd0);
    send_range(REQ_SUM, 13'd1, 13'd4096, 64'd0);
    // Rejected: zero low, inverted, beyond count, all-ones fields; then one valid sum
    send_range(REQ_ADD, 13'd0, 13'd5, 64'd7);
    send_range(REQ_SUM, 13'd9, 13'd8, 64'd0);
    send_range(REQ_ADD, 13'd1, 13'd4097, 64'd3);
    send_range(REQ_SUM, 13'h1fff, 13'h1fff, 64'd0);
    send_range(REQ_SUM, 13'd2, 13'd4095, 64'd0);
  endtask

  task automatic test_count_edges();
    write_count(13'd1);
    send_range(REQ_ADD, 13'd1, 13'd1, 64'd5);
    send_range(REQ_SUM, 13'd1, 13'd1, 64'd0);
    send_range(REQ_SUM, 13'd1, 13'd2, 64'd0);
    // Zero acts as one, above the maximum acts as the maximum
    write_count(13'd0);
    send_range(REQ_SUM, 13'd1, 13'd1, 64'd0);
    send_range(REQ_SUM, 13'd1, 13'd2, 64'd0);
    write_count(13'h1fff);
    send_range(REQ_SUM, 13'd1, 13'd4096, 64'd0);
    send_range(REQ_SUM, 13'd1, 13'd4097, 64'd0);
  endtask

  task automatic test_random_phases();
    int counts[5] = '{4096, 2, 7, 100, 4096};
    int n;
    for (int p = 0; p < 5; p++) begin
      write_count(13'(counts[p]));
      n = counts[p];
      for (int i = 0; i < RandItems / 5; i++) rand_item(n);
    end
  endtask

  // Compare every result strobe against the oldest expectation
  always @(posedge clk_i) begin
    sum_result_t want;
    if (rst_ni && done_o) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_sums.pop_front();
        if (range_sum_o !== want.sum)
          report_mismatch($sformatf("range_sum %h, want %h", range_sum_o, want.sum));
        if (range_error_o !== want.err)
          report_mismatch($sformatf("range_error %b, want %b", range_error_o, want.err));
      end
    end
  end

  // Stop the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    shadow_count = 13'd4096;
    for (int i = 0; i < TreeNodes; i++) begin
      shadow_sums[i] = '0;
      shadow_tags[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_extremes();
    test_count_edges();
    test_random_phases();
    drain();
    repeat (20) @(negedge clk_i);
    if (error_count == 0 && pending_sums.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
